// ===== rtl/usi_pkg.sv =====
`timescale 1ns / 1ps

package usi_pkg;

    // Run length limits and field widths
    localparam int MAX_POINTS  = 65536;
    localparam int SAMPLE_BITS = 32;
    localparam int COUNT_W     = 17;
    localparam int STEP_W      = 32;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int ACC_W       = 56;
    localparam int OUT_W       = 48;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MIN   = 17'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_POINTS);
    localparam logic [COUNT_W-1:0] COUNT_RESET = 17'd3;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 32'h0100_0000;

    // Depth of the job queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One finished run handed from the front end to the back end
    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic                    sat;
        logic [STEP_W-1:0]       step;
    } t_job;

endpackage

// ===== rtl/uniform_simpson_integrator.sv =====
`timescale 1ns / 1ps

// Uniform-step integrator: each run of point_count samples (Q16.16, one word
// per cycle) is summed with composite Simpson 1/3 weights, with the 3/8 rule
// over the last four points when the count is even (the 3/8 rule alone for a
// count of four). After the last sample the sum is scaled by step_size
// (Q8.24) and divided by 24, rounded to nearest with ties away from zero, and
// one Q32.16 word leaves on the master side with tuser set when it saturated.
// A sample is taken every cycle unless the last sample of a run waits on a
// full job queue; the weight selection and 56-bit saturating accumulate in
// the front end set that rate. The back-end pipe holds the magnitude split,
// a 32x32 and a 24x32 partial product, the scaling add, and seven byte-wide
// stages of division by three. A two-deep job queue lets new runs stream in
// while results wait on a stalled output. Writing point_count drops the run
// in progress; step_size is sampled at the end of each run. Counts (low 17
// bits of the word) below 3 act as 3 and above 65536 act as 65536.

module uniform_simpson_integrator import usi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // sample_value [31:0]
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [SAMPLE_BITS-1:0] i_s_axis_tdata,
    // integral_value [47:0]
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_W-1:0]       o_m_axis_tdata,
    // overflow_flag [0]
    output logic                   o_m_axis_tuser,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic push;
    logic queue_full;
    logic queue_valid;
    logic pop;
    t_job push_job;
    t_job pop_job;

    usi_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_queue_full    (queue_full),
        .o_push          (push),
        .o_job           (push_job)
    );

    usi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_job   (pop_job)
    );

    usi_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (queue_valid),
        .i_job           (pop_job),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

// ===== rtl/usi_front.sv =====
`timescale 1ns / 1ps

module usi_front import usi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [SAMPLE_BITS-1:0] i_s_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_queue_full,
    output logic                   o_push,
    output t_job                   o_job
);

    localparam int WEIGHT_W = 6;
    localparam int PROD_W   = SAMPLE_BITS + WEIGHT_W + 1;

    localparam logic [WEIGHT_W-1:0] W_END   = 6'd8;
    localparam logic [WEIGHT_W-1:0] W_ODD   = 6'd32;
    localparam logic [WEIGHT_W-1:0] W_EVEN  = 6'd16;
    localparam logic [WEIGHT_W-1:0] W_OUTER = 6'd9;
    localparam logic [WEIGHT_W-1:0] W_INNER = 6'd27;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Run geometry, derived once per count write
    logic [IDX_W-1:0] r_last;
    logic [IDX_W-1:0] r_m;
    logic             r_even;
    logic             r_m_ge2;
    logic [STEP_W-1:0] r_step;

    // Run state
    logic [IDX_W-1:0]        r_idx;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_sat;

    logic [COUNT_W-1:0]      cfg_count;
    logic [COUNT_W-1:0]      n_count;
    logic                    cfg_count_wr;
    logic                    is_last;
    logic                    accept;
    logic [IDX_W:0]          pos_off;
    logic                    in_simpson;
    logic [WEIGHT_W-1:0]     weight;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W:0]   sum;
    logic                    ovf;
    logic signed [ACC_W-1:0] n_acc;

    // Clamp the written count to the supported run length
    assign cfg_count    = i_cfg_data[COUNT_W-1:0];
    assign cfg_count_wr = i_cfg_we && (i_cfg_index == CFG_POINT_COUNT);

    always_comb begin
        if (!cfg_count_wr) begin
            n_count = COUNT_RESET;
        end else if (cfg_count < COUNT_MIN) begin
            n_count = COUNT_MIN;
        end else if (cfg_count > COUNT_MAX) begin
            n_count = COUNT_MAX;
        end else begin
            n_count = cfg_count;
        end
    end

    assign is_last = (r_idx == r_last);
    assign pos_off = {1'b0, r_idx} - {1'b0, r_m};
    assign in_simpson = r_m_ge2 && (pos_off[IDX_W] || (pos_off == '0));

    // Select the weight (24 times the rule weight) for this position
    always_comb begin
        weight = '0;
        if (!r_even) begin
            if ((r_idx == '0) || is_last) begin
                weight = W_END;
            end else if (r_idx[0]) begin
                weight = W_ODD;
            end else begin
                weight = W_EVEN;
            end
        end else begin
            if (in_simpson) begin
                if ((r_idx == '0) || (pos_off == '0)) begin
                    weight = W_END;
                end else if (r_idx[0]) begin
                    weight = W_ODD;
                end else begin
                    weight = W_EVEN;
                end
            end
            if ((pos_off == (IDX_W+1)'(0)) || (pos_off == (IDX_W+1)'(3))) begin
                weight = weight + W_OUTER;
            end else if ((pos_off == (IDX_W+1)'(1)) || (pos_off == (IDX_W+1)'(2))) begin
                weight = weight + W_INNER;
            end
        end
    end

    // Weighted accumulate with saturation
    assign prod = $signed(i_s_axis_tdata) * $signed({1'b0, weight});
    assign sum  = $signed({r_acc[ACC_W-1], r_acc}) + (ACC_W+1)'(prod);
    assign ovf  = (sum[ACC_W] != sum[ACC_W-1]);
    assign n_acc = ovf ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];

    // Hold the last sample only while the queue has no room
    assign o_s_axis_tready = !(is_last && i_queue_full);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_push          = accept && is_last;
    assign o_job.acc       = n_acc;
    assign o_job.sat       = r_sat || ovf;
    assign o_job.step      = r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_RESET;
            r_idx   <= '0;
            r_acc   <= '0;
            r_sat   <= 1'b0;
            r_last  <= IDX_W'(COUNT_RESET - 1'b1);
            r_m     <= IDX_W'(COUNT_RESET - 3'd4);
            r_even  <= !COUNT_RESET[0];
            r_m_ge2 <= (COUNT_RESET >= COUNT_W'(6));
        end else begin
            if (cfg_count_wr) begin
                // A count write drops the run in progress
                r_last  <= IDX_W'(n_count - 1'b1);
                r_m     <= IDX_W'(n_count - 3'd4);
                r_even  <= !n_count[0];
                r_m_ge2 <= (n_count >= COUNT_W'(6));
                r_idx   <= '0;
                r_acc   <= '0;
                r_sat   <= 1'b0;
            end else if (accept) begin
                if (is_last) begin
                    r_idx <= '0;
                    r_acc <= '0;
                    r_sat <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                    r_acc <= n_acc;
                    r_sat <= r_sat || ovf;
                end
            end
            if (i_cfg_we && (i_cfg_index == CFG_STEP_SIZE)) begin
                r_step <= i_cfg_data[STEP_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/usi_queue.sv =====
`timescale 1ns / 1ps

module usi_queue import usi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store jobs
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/usi_back.sv =====
`timescale 1ns / 1ps

module usi_back import usi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  t_job             i_job,
    output logic             o_pop,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,
    output logic             o_m_axis_tuser
);

    localparam int HI_W       = ACC_W - 32;
    localparam int LO_W       = 32;
    localparam int PLO_W      = LO_W + STEP_W;
    localparam int PHI_W      = HI_W + STEP_W;
    localparam int P_W        = PHI_W + LO_W + 1;
    localparam int SHIFT      = 27;
    localparam int T_W        = P_W - SHIFT;
    localparam int KEEP_W     = 50;
    localparam int DIGIT_W    = 8;
    localparam int DIV_W      = 56;
    localparam int DIV_STAGES = DIV_W / DIGIT_W;

    localparam logic [P_W-1:0]   ROUND_HALF = P_W'(3) << (SHIFT - 1);
    localparam logic [2:0]       DIVISOR    = 3'd3;
    localparam logic [DIV_W-1:0] NEG_MAG    = DIV_W'(1) << (OUT_W - 1);
    localparam logic [DIV_W-1:0] POS_MAX    = NEG_MAG - 1'b1;
    localparam logic [OUT_W-1:0] OUT_MAX    = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN    = {1'b1, {(OUT_W-1){1'b0}}};

    // Long division by three, one byte of quotient per call
    function automatic logic [DIGIT_W+1:0] f_div3_digit(
        input logic [1:0]         rem_in,
        input logic [DIGIT_W-1:0] digits
    );
        logic [2:0]         r;
        logic [DIGIT_W-1:0] q;
        r = {1'b0, rem_in};
        q = '0;
        for (int b = DIGIT_W - 1; b >= 0; b--) begin
            r = {r[1:0], digits[b]};
            if (r >= DIVISOR) begin
                q[b] = 1'b1;
                r    = r - DIVISOR;
            end
        end
        return {r[1:0], q};
    endfunction

    logic en;

    // Stage A: magnitude split
    logic              r_a_vld;
    logic              r_a_neg;
    logic              r_a_sat;
    logic [HI_W-1:0]   r_a_hi;
    logic [LO_W-1:0]   r_a_lo;
    logic [STEP_W-1:0] r_a_step;
    logic [ACC_W-1:0]  mag;

    // Stage B: partial products
    logic             r_b_vld;
    logic             r_b_neg;
    logic             r_b_sat;
    logic [PLO_W-1:0] r_b_lo;
    logic [PHI_W-1:0] r_b_hi;

    // Stage C and divider stages
    logic [P_W-1:0] prod_sum;
    logic [T_W-1:0] scaled;
    logic           big;

    logic             r_d_vld [DIV_STAGES+1];
    logic             r_d_neg [DIV_STAGES+1];
    logic             r_d_sat [DIV_STAGES+1];
    logic [DIV_W-1:0] r_d_val [DIV_STAGES+1];
    logic [1:0]       r_d_rem [DIV_STAGES];
    logic [DIGIT_W+1:0] div_res [DIV_STAGES];

    // Output register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             r_out_user;
    logic [DIV_W-1:0] quot;
    logic             fin_neg;
    logic             fin_sat;
    logic [OUT_W-1:0] fin_data;

    // The whole pipe moves unless a finished word waits
    assign en    = !r_out_valid || i_m_axis_tready;
    assign o_pop = en && i_job_valid;

    assign mag = i_job.acc[ACC_W-1] ? ACC_W'(-i_job.acc) : i_job.acc;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_neg  <= i_job.acc[ACC_W-1];
            r_a_sat  <= i_job.sat;
            r_a_hi   <= mag[ACC_W-1:LO_W];
            r_a_lo   <= mag[LO_W-1:0];
            r_a_step <= i_job.step;
            r_b_neg  <= r_a_neg;
            r_b_sat  <= r_a_sat;
            r_b_lo   <= r_a_lo * r_a_step;
            r_b_hi   <= r_a_hi * r_a_step;
        end
    end

    // Scale and round: T = (|acc| * step + 3 * 2^26) >> 27, then T / 3
    assign prod_sum = {1'b0, r_b_hi, {LO_W{1'b0}}} + P_W'(r_b_lo) + ROUND_HALF;
    assign scaled   = prod_sum[P_W-1:SHIFT];
    assign big      = |scaled[T_W-1:KEEP_W];

    // Divide one byte per stage, top byte first
    always_comb begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            div_res[s] = f_div3_digit(r_d_rem[s], r_d_val[s][DIV_W-1 -: DIGIT_W]);
        end
    end

    // Advance the divider stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_neg[0] <= r_b_neg;
            r_d_sat[0] <= r_b_sat || big;
            r_d_val[0] <= DIV_W'(scaled[KEEP_W-1:0]);
            r_d_rem[0] <= '0;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_d_neg[s+1] <= r_d_neg[s];
                r_d_sat[s+1] <= r_d_sat[s];
                r_d_val[s+1] <= {r_d_val[s][DIV_W-DIGIT_W-1:0], div_res[s][DIGIT_W-1:0]};
            end
            for (int s = 0; s < DIV_STAGES - 1; s++) begin
                r_d_rem[s+1] <= div_res[s][DIGIT_W+1:DIGIT_W];
            end
        end
    end

    // Saturate and restore the sign
    assign quot    = r_d_val[DIV_STAGES];
    assign fin_neg = r_d_neg[DIV_STAGES];
    assign fin_sat = r_d_sat[DIV_STAGES] || (fin_neg ? (quot > NEG_MAG) : (quot > POS_MAX));

    always_comb begin
        if (fin_sat) begin
            fin_data = fin_neg ? OUT_MIN : OUT_MAX;
        end else if (fin_neg) begin
            fin_data = OUT_W'(-quot[OUT_W-1:0]);
        end else begin
            fin_data = quot[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= fin_data;
            r_out_user <= fin_sat;
        end
    end

    // Valid bits of every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int s = 0; s <= DIV_STAGES; s++) begin
                r_d_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_a_vld    <= i_job_valid;
            r_b_vld    <= r_a_vld;
            r_d_vld[0] <= r_b_vld;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_d_vld[s+1] <= r_d_vld[s];
            end
            r_out_valid <= r_d_vld[DIV_STAGES];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

// ===== rtl/usi_checker.sv =====
`timescale 1ns / 1ps

module usi_checker import usi_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_W-1:0]       o_m_axis_tdata,
    input logic                   o_m_axis_tuser,
    input logic                   i_cfg_we,
    input logic [CFG_IDX_W-1:0]   i_cfg_index
);

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result word changed while stalled");

    // A saturated result sits at one of the two limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
            ((o_m_axis_tdata == OUT_MAX) || (o_m_axis_tdata == OUT_MIN)))
        else $error("overflow flag without a saturated value");

    // Nothing leaves right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result word right after reset");

    // The job queue is empty after reset, so samples are taken
    a_reset_ready: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> o_s_axis_tready)
        else $error("sample input stalled right after reset");

    // A count write restarts the run, so the next sample is taken
    a_count_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_index == CFG_POINT_COUNT)) |=> o_s_axis_tready)
        else $error("sample input stalled after a count write");

endmodule

bind uniform_simpson_integrator usi_checker u_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import usi_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 11;
    localparam int PIPE_GUARD   = 20;     // covers the result pipe
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_ITEMS = 800;

    localparam longint ACC_HI = 64'sh007F_FFFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam logic [127:0] OUT_POS_MAX = 128'h7FFF_FFFF_FFFF;
    localparam logic [127:0] OUT_NEG_MAG = 128'h8000_0000_0000;

    typedef struct {
        logic [OUT_W-1:0] integral;
        logic             ovf;
    } t_integral_exp;

    logic                   i_clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [SAMPLE_BITS-1:0] s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_W-1:0]       m_tdata;
    logic                   m_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Integrator state mirrored by the predictor
    logic [COUNT_W-1:0] pt_count = COUNT_RESET;
    logic [STEP_W-1:0]  step_h = STEP_RESET;
    int unsigned        run_pos = 0;
    longint             wsum = 0;
    bit                 wsum_sat = 1'b0;

    logic [SAMPLE_BITS-1:0] sample_q[$];
    t_integral_exp          integral_q[$];

    int samples_queued = 0;
    int samples_taken = 0;
    int results_checked = 0;
    int sat_results = 0;
    int cfg_writes = 0;
    int mismatches = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    int unsigned calm_left = 200;
    bit calm = 1'b0;
    int idle_cycles = 0;

    uniform_simpson_integrator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),     // sample_value [31:0]
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),     // integral_value [47:0]
        .o_m_axis_tuser  (m_tuser),     // overflow_flag [0]
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Run length after clamping the count register
    function automatic int unsigned eff_count();
        int unsigned n;
        n = pt_count;
        if (n < 3) n = 3;
        if (n > MAX_POINTS) n = MAX_POINTS;
        return n;
    endfunction

    // Simpson 1/3 weights times 24 over points 0..last_i
    function automatic longint simpson_w(int unsigned i, int unsigned last_i);
        if (i == 0 || i == last_i) return 8;
        return i[0] ? 32 : 16;
    endfunction

    // Weight of point i in a run of n; even runs end with the 3/8 rule
    function automatic longint sample_weight(int unsigned i, int unsigned n);
        int unsigned m;
        longint w;
        if (n[0]) return simpson_w(i, n - 1);
        m = n - 4;
        w = 0;
        if (m >= 2 && i <= m) w += simpson_w(i, m);
        if (i == m || i == m + 3) w += 9;
        else if (i == m + 1 || i == m + 2) w += 27;
        return w;
    endfunction

    // Accumulate one sample; at the end of a run, scale, round and saturate
    function automatic void absorb_sample(logic [SAMPLE_BITS-1:0] raw);
        int unsigned n;
        longint acc;
        logic [63:0] mag;
        logic [127:0] prod;
        logic [127:0] q;
        logic [OUT_W-1:0] mag48;
        bit neg;
        bit sat;
        t_integral_exp r;
        n = eff_count();
        acc = wsum + sample_weight(run_pos, n) * longint'($signed(raw));
        if (acc > ACC_HI) begin
            acc = ACC_HI;
            wsum_sat = 1'b1;
        end else if (acc < ACC_LO) begin
            acc = ACC_LO;
            wsum_sat = 1'b1;
        end
        wsum = acc;
        if (run_pos + 1 < n) begin
            run_pos++;
            return;
        end
        // acc * h / (24 * 2^24), nearest with ties away from zero
        neg = acc < 0;
        mag = neg ? 64'(-acc) : 64'(acc);
        prod = 128'(mag) * 128'(step_h);
        q = (prod + (128'd3 << 26)) / (128'd3 << 27);
        sat = wsum_sat;
        if (neg) begin
            if (q > OUT_NEG_MAG) sat = 1'b1;
            mag48 = sat ? OUT_NEG_MAG[OUT_W-1:0] : q[OUT_W-1:0];
            r.integral = -mag48;
        end else begin
            if (q > OUT_POS_MAX) sat = 1'b1;
            r.integral = sat ? OUT_POS_MAX[OUT_W-1:0] : q[OUT_W-1:0];
        end
        r.ovf = sat;
        if (sat) sat_results++;
        integral_q.push_back(r);
        run_pos = 0;
        wsum = 0;
        wsum_sat = 1'b0;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
    endtask

    // Toggle stretches where neither side idles
    always @(posedge i_clk) begin
        if (calm_left == 0) begin
            calm <= ~calm;
            calm_left <= $urandom_range(50, 400);
        end else begin
            calm_left <= calm_left - 1;
        end
    end

    // Sample driver: one word per handshake, random gaps between words
    always @(posedge i_clk) begin : sample_driver
        int unsigned r;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (sample_q.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= sample_q.pop_front();
                r = $urandom_range(0, 99);
                if (calm || r < 55) gap_left <= 0;
                else if (r < 90) gap_left <= $urandom_range(1, 3);
                else gap_left <= $urandom_range(4, 30);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin : result_receiver
        int unsigned r;
        if (!rst_n) begin
            m_tready <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_tready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_served <= hold_served + 1;
        end else begin
            r = $urandom_range(0, 99);
            if (calm) begin
                m_tready <= 1'b1;
            end else if (r < 3) begin
                m_tready <= 1'b0;
                hold_left <= $urandom_range(5, 60);
            end else begin
                m_tready <= (r >= 30);
            end
        end
    end

    // Predict on every accepted sample
    always @(posedge i_clk) begin
        if (rst_n && s_tvalid && s_tready) begin
            samples_taken++;
            absorb_sample(s_tdata);
        end
    end

    // Check every accepted result against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_integral_exp want;
        if (rst_n && m_tvalid && m_tready) begin
            results_checked++;
            if (integral_q.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_tdata), 64'd0);
            end else begin
                want = integral_q.pop_front();
                if (m_tdata !== want.integral)
                    report_mismatch("integral_value", 64'(m_tdata), 64'(want.integral));
                if (m_tuser !== want.ovf)
                    report_mismatch("overflow_flag", 64'(m_tuser), 64'(want.ovf));
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Write one register and mirror it in the predictor
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_POINT_COUNT) begin
            pt_count = data[COUNT_W-1:0];
            run_pos = 0;
            wsum = 0;
            wsum_sat = 1'b0;
        end else begin
            step_h = data;
        end
        cfg_writes++;
    endtask

    task automatic queue_sample(logic [SAMPLE_BITS-1:0] v);
        sample_q.push_back(v);
        samples_queued++;
    endtask

    // Queue k samples: mostly random, some small, some at the extremes
    task automatic push_run(int k);
        logic [SAMPLE_BITS-1:0] v;
        @(negedge i_clk);
        repeat (k) begin
            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 3))
                        0: v = 32'h7FFF_FFFF;
                        1: v = 32'h8000_0000;
                        2: v = 32'h0000_0000;
                        default: v = 32'hFFFF_FFFF;
                    endcase
                end
                1, 2: v = 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
                default: v = $urandom();
            endcase
            queue_sample(v);
        end
    endtask

    // Wait for all samples taken and all results checked, then the pipe
    task automatic wait_drained();
        while (samples_taken != samples_queued || integral_q.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_GUARD) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int random_items;
        int phase;
        int runs;
        int n;
        int tail;
        int unsigned r;
        logic [CFG_DATA_W-1:0] cnt_val;
        logic [CFG_DATA_W-1:0] step_val;

        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset setting, sample extremes
        @(negedge i_clk);
        queue_sample(32'h7FFF_FFFF);
        queue_sample(32'h8000_0000);
        queue_sample(32'h0001_0000);
        wait_drained();

        // Count of four: 3/8 rule alone
        write_reg(CFG_POINT_COUNT, 32'd4);
        @(negedge i_clk);
        queue_sample(32'h7FFF_FFFF);
        queue_sample(32'h7FFF_FFFF);
        queue_sample(32'h7FFF_FFFF);
        queue_sample(32'h8000_0000);
        wait_drained();

        // Count of six: Simpson and 3/8 share one point
        write_reg(CFG_POINT_COUNT, 32'd6);
        push_run(6);
        wait_drained();

        // Count below three acts as three; unit step makes exact ties
        write_reg(CFG_POINT_COUNT, 32'd0);
        write_reg(CFG_STEP_SIZE, 32'd1);
        @(negedge i_clk);
        queue_sample(32'd0);
        queue_sample(32'd6291456);
        queue_sample(32'd0);
        queue_sample(32'd0);
        queue_sample(-32'sd6291456);
        queue_sample(32'd0);
        wait_drained();

        // Zero step
        write_reg(CFG_STEP_SIZE, 32'd0);
        write_reg(CFG_POINT_COUNT, 32'd2);
        push_run(3);
        wait_drained();

        // Drop a partial run by rewriting the count
        push_run(2);
        wait_drained();
        write_reg(CFG_POINT_COUNT, 32'd3);

        // Rewrite the step in the middle of a run
        push_run(1);
        wait_drained();
        write_reg(CFG_STEP_SIZE, 32'hFFFF_FFFF);
        push_run(2);
        wait_drained();

        // Random phases, with a back-pressure phase and a saturation phase
        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (phase == 1) begin
                // Short runs while the receiver holds off: fill the block
                write_reg(CFG_POINT_COUNT, 32'd3);
                hold_requests++;
                push_run(90);
                random_items += 90;
            end else if (phase == 3) begin
                // Full-scale samples and step: saturate both ways
                write_reg(CFG_POINT_COUNT, 32'd300);
                write_reg(CFG_STEP_SIZE, 32'hFFFF_FFFF);
                @(negedge i_clk);
                repeat (300) queue_sample(32'h7FFF_FFFF);
                repeat (300) queue_sample(32'h8000_0000);
                random_items += 600;
            end else begin
                if (phase == 0 || $urandom_range(0, 2) != 0) begin
                    r = $urandom_range(0, 19);
                    if (r == 0) cnt_val = $urandom_range(0, 2);
                    else if (r < 4) cnt_val = $urandom_range(13, 64);
                    else cnt_val = $urandom_range(3, 12);
                    write_reg(CFG_POINT_COUNT, cnt_val);
                end
                if (phase == 0 || $urandom_range(0, 1) != 0) begin
                    case ($urandom_range(0, 7))
                        0: step_val = 32'd0;
                        1: step_val = 32'hFFFF_FFFF;
                        2: step_val = STEP_RESET;
                        3: step_val = $urandom_range(1, 255);
                        default: step_val = $urandom();
                    endcase
                    write_reg(CFG_STEP_SIZE, step_val);
                end
                n = eff_count();
                runs = $urandom_range(1, 4);
                push_run(n * runs);
                random_items += n * runs;
                // Sometimes leave a partial run for the next phase
                if ($urandom_range(0, 3) == 0) begin
                    tail = $urandom_range(1, n - 1);
                    push_run(tail);
                    random_items += tail;
                end
            end
            wait_drained();
            phase++;
        end

        // Largest count field clamps to the longest run: part of one gives no result
        write_reg(CFG_POINT_COUNT, 32'h0001_FFFF);
        write_reg(CFG_STEP_SIZE, $urandom());
        push_run(200);
        wait_drained();

        $display("Checked %0d integrals (%0d saturated) over %0d samples, %0d register writes.",
                 results_checked, sat_results, samples_taken, cfg_writes);
        $display("Counts ran from below three to an oversized field; steps from zero to full scale.");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== uniform_simpson_integrator.f =====
rtl/usi_pkg.sv
rtl/usi_front.sv
rtl/usi_queue.sv
rtl/usi_back.sv
rtl/uniform_simpson_integrator.sv
rtl/usi_checker.sv
sim/tb.sv
